/* src/contour_segment_extractor_assert.svh */
// Assertion helpers for the contour segment extractor RTL.
`ifndef CONTOUR_SEGMENT_EXTRACTOR_ASSERT_SVH
`define CONTOUR_SEGMENT_EXTRACTOR_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define CSE_ASSERT_NOW(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("contour segment extractor check failed");

// The condition must hold in the cycle after the trigger.
`define CSE_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("contour segment extractor check failed");

`endif

/* src/cse_pkg.sv */
// ----------------------------------------------------------------------------
// cse_pkg
// Types, sizes and constants shared by the contour segment extractor.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int MAX_ROW_LENGTH = 1024;
    localparam int MAX_ROWS       = 4096;
    localparam int MAX_LEVELS     = 4;
    localparam int QUEUE_DEPTH    = 2;

    localparam int LEN_W    = $clog2(MAX_ROW_LENGTH + 1);
    localparam int COL_W    = $clog2(MAX_ROW_LENGTH);
    localparam int ROWS_W   = $clog2(MAX_ROWS + 1);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int NLEV_W   = 3;
    localparam int LEV_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int F_W      = SAMPLE_BITS + 4;
    localparam int COORD_W  = 17;
    localparam int QUO_W    = 17;
    localparam int QPTR_W   = $clog2(QUEUE_DEPTH);

    localparam logic [COORD_W-1:0] ONE_Q16  = COORD_W'(65536);
    localparam logic [COORD_W-1:0] HALF_Q16 = COORD_W'(32768);

    // Corner placement per triangle, bit i belongs to triangle i.
    localparam logic [3:0] CORNER0_X = 4'b0110;
    localparam logic [3:0] CORNER0_Y = 4'b1100;
    localparam logic [3:0] CORNER1_X = 4'b0011;
    localparam logic [3:0] CORNER1_Y = 4'b0110;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_LENGTH  = 3'd0,
        CFG_ROW_COUNT   = 3'd1,
        CFG_LEVEL_COUNT = 3'd2,
        CFG_LEVEL_A     = 3'd3,
        CFG_LEVEL_B     = 3'd4,
        CFG_LEVEL_C     = 3'd5,
        CFG_LEVEL_D     = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_EVAL,
        ST_DIV,
        ST_EMIT,
        ST_FLUSH
    } t_back_state;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [ROWS_W-1:0] rows;
        logic [NLEV_W-1:0] nlev;
        logic [MAX_LEVELS-1:0][SAMPLE_BITS-1:0] levels;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] v00;
        logic [SAMPLE_BITS-1:0] v01;
        logic [SAMPLE_BITS-1:0] v10;
        logic [SAMPLE_BITS-1:0] v11;
        logic [COL_W-1:0]       col;
        logic [ROW_W-1:0]       row;
    } t_cell;

    typedef struct packed {
        logic [COL_W-1:0]   cell_column;
        logic [ROW_W-1:0]   cell_row;
        logic [LEV_W-1:0]   level_index;
        logic [1:0]         triangle;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic               last;
    } t_seg;

    function automatic logic signed [F_W-1:0] sext(input logic [SAMPLE_BITS-1:0] v);
        return {{(F_W - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
    endfunction

endpackage

/* src/cse_pix_if.sv */
// ----------------------------------------------------------------------------
// cse_pix_if
// Pixel stream channel: one sample per beat in raster order.
// ----------------------------------------------------------------------------
interface cse_pix_if;
    import cse_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   frame_start;

    modport source (output valid, output sample, output frame_start, input ready);
    modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

/* src/cse_seg_if.sv */
// ----------------------------------------------------------------------------
// cse_seg_if
// Segment stream channel: one contour segment per beat.
// ----------------------------------------------------------------------------
interface cse_seg_if;
    import cse_pkg::*;

    logic               valid;
    logic               ready;
    logic [COL_W-1:0]   cell_column;
    logic [ROW_W-1:0]   cell_row;
    logic [LEV_W-1:0]   level_index;
    logic [1:0]         triangle;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic               last;

    modport source (output valid, output cell_column, output cell_row,
                    output level_index, output triangle, output start_x,
                    output start_y, output end_x, output end_y, output last,
                    input ready);
    modport sink   (input valid, input cell_column, input cell_row,
                    input level_index, input triangle, input start_x,
                    input start_y, input end_x, input end_y, input last,
                    output ready);
endinterface

/* src/contour_segment_extractor.sv */
// Flow: a pixel's cell is registered in the front and pushed into the cell queue once
// the queue has room. The back walks each cell's levels and triangles, runs two
// 17-step crossing divisions per segment in one shared divider, then emits the segment.
// Throughput: one pixel per cycle while the cell queue has room; the back takes a new
// cell only once the previous one is done. Reset: synchronous, active low; clears
// position, neighbor samples, queue and handshakes, not the line buffer.
// ----------------------------------------------------------------------------
// contour_segment_extractor
// Marching-triangles contour extraction over a raster pixel stream.
// ----------------------------------------------------------------------------
module contour_segment_extractor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cse_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cse_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cse_pix_if.sink                        i_pix,
    cse_seg_if.source                      o_seg
);
    import cse_pkg::*;

    logic [10:0]            r_row_length;
    logic [12:0]            r_row_count;
    logic [2:0]             r_level_count;
    logic [SAMPLE_BITS-1:0] r_level [MAX_LEVELS];
    t_cfg                   cfg;

    logic  q_push, q_full, q_pop, q_valid;
    t_cell q_in, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length  <= 11'd1024;
            r_row_count   <= 13'd4096;
            r_level_count <= 3'd1;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_level[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROW_LENGTH:  r_row_length  <= i_cfg_data[10:0];
                CFG_ROW_COUNT:   r_row_count   <= i_cfg_data[12:0];
                CFG_LEVEL_COUNT: r_level_count <= i_cfg_data[2:0];
                CFG_LEVEL_A:     r_level[0]    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_LEVEL_B:     r_level[1]    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_LEVEL_C:     r_level[2]    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_LEVEL_D:     r_level[3]    <= i_cfg_data[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Registers are used clamped to their legal ranges.
    always_comb begin
        cfg.len = (r_row_length < 11'd2) ? LEN_W'(2)
                : (r_row_length > 11'(MAX_ROW_LENGTH)) ? LEN_W'(MAX_ROW_LENGTH)
                : LEN_W'(r_row_length);
        cfg.rows = (r_row_count < 13'd2) ? ROWS_W'(2)
                 : (r_row_count > 13'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS)
                 : ROWS_W'(r_row_count);
        cfg.nlev = (r_level_count < 3'd1) ? NLEV_W'(1)
                 : (r_level_count > 3'(MAX_LEVELS)) ? NLEV_W'(MAX_LEVELS)
                 : r_level_count;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            cfg.levels[i] = r_level[i];
        end
    end

    cse_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_pix    (i_pix),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cell (q_in)
    );

    cse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cell  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cell  (q_out)
    );

    cse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_cell  (q_out),
        .o_q_pop   (q_pop),
        .o_seg     (o_seg)
    );
endmodule

/* src/cse_ram.sv */
// ----------------------------------------------------------------------------
// cse_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module cse_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* src/cse_front.sv */
// ----------------------------------------------------------------------------
// cse_front
// Tracks raster position, keeps the line buffer and forms 2x2 cells.
// ----------------------------------------------------------------------------
module cse_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cse_pkg::t_cfg   i_cfg,
    cse_pix_if.sink         i_pix,
    input  logic            i_q_full,
    output logic            o_q_push,
    output cse_pkg::t_cell  o_q_cell
);
    import cse_pkg::*;

    logic [COL_W-1:0]       r_col;
    logic [ROW_W-1:0]       r_row;
    logic [SAMPLE_BITS-1:0] r_left;
    logic [SAMPLE_BITS-1:0] r_left_above;
    logic                   r_s1_v;
    logic                   r_s1_cell;
    logic [SAMPLE_BITS-1:0] r_s1_s;
    logic [COL_W-1:0]       r_s1_col;
    logic [ROW_W-1:0]       r_s1_row;

    logic                   accept;
    logic                   s1_retire;
    logic [LEN_W-1:0]       col;
    logic [ROWS_W-1:0]      row;
    logic [LEN_W-1:0]       col_nx;
    logic [ROWS_W-1:0]      row_nx;
    logic [SAMPLE_BITS-1:0] above;

    assign s1_retire = r_s1_v && (!r_s1_cell || !i_q_full);
    assign i_pix.ready = !r_s1_v || s1_retire;
    assign accept = i_pix.valid && i_pix.ready;

    always_comb begin
        col = i_pix.frame_start ? '0 : LEN_W'(r_col);
        row = i_pix.frame_start ? '0 : ROWS_W'(r_row);
        if (col >= i_cfg.len) begin
            col = '0;
            row = row + ROWS_W'(1);
        end
        if (row >= i_cfg.rows) begin
            row = '0;
        end
        col_nx = col + LEN_W'(1);
        row_nx = row;
        if (col_nx >= i_cfg.len) begin
            col_nx = '0;
            row_nx = row + ROWS_W'(1);
            if (row_nx >= i_cfg.rows) begin
                row_nx = '0;
            end
        end
    end

    cse_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_ROW_LENGTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (col[COL_W-1:0]),
        .i_wdata (i_pix.sample),
        .i_re    (accept),
        .i_raddr (col[COL_W-1:0]),
        .o_rdata (above)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_left       <= '0;
            r_left_above <= '0;
            r_s1_v       <= 1'b0;
        end else begin
            if (s1_retire) begin
                r_left_above <= above;
                r_left       <= r_s1_s;
            end
            if (accept) begin
                r_col  <= col_nx[COL_W-1:0];
                r_row  <= row_nx[ROW_W-1:0];
                r_s1_v <= 1'b1;
            end else if (s1_retire) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_s    <= i_pix.sample;
            r_s1_col  <= col[COL_W-1:0] - COL_W'(1);
            r_s1_row  <= row[ROW_W-1:0];
            r_s1_cell <= (col != '0) && (row != '0);
        end
    end

    assign o_q_push      = r_s1_v && r_s1_cell && !i_q_full;
    assign o_q_cell.v00  = r_left_above;
    assign o_q_cell.v01  = above;
    assign o_q_cell.v10  = r_left;
    assign o_q_cell.v11  = r_s1_s;
    assign o_q_cell.col  = r_s1_col;
    assign o_q_cell.row  = r_s1_row;
endmodule

/* src/cse_queue.sv */
// ----------------------------------------------------------------------------
// cse_queue
// Short cell queue between the front and the back.
// ----------------------------------------------------------------------------
module cse_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cse_pkg::t_cell i_cell,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output cse_pkg::t_cell o_cell
);
    import cse_pkg::*;

    t_cell              r_ent [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QPTR_W:0]    r_cnt;

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cell  = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QPTR_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (QPTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_cell;
        end
    end
endmodule

/* src/cse_back.sv */
// ----------------------------------------------------------------------------
// cse_back
// Walks levels and triangles of one cell, divides out crossings bit by bit
// and delivers segments, holding one back so the final one can carry last.
// ----------------------------------------------------------------------------
module cse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cse_pkg::t_cfg  i_cfg,
    input  logic           i_q_valid,
    input  cse_pkg::t_cell i_q_cell,
    output logic           o_q_pop,
    cse_seg_if.source      o_seg
);
    import cse_pkg::*;
    `include "contour_segment_extractor_assert.svh"

    typedef struct packed {
        logic pop;
        logic load_f;
        logic start;
        logic step;
        logic emit;
        logic flush_out;
        logic adv;
    } t_back_ctl;

    t_back_state r_state, n_state;
    t_back_ctl   ctl;

    t_cell                  r_cell;
    logic [LEV_W-1:0]       r_li;
    logic [1:0]             r_leg;
    logic signed [F_W-1:0]  r_fv [2][2];
    logic signed [F_W-1:0]  r_fc;
    logic [1:0]             r_edge;
    logic [1:0]             r_edge_b;
    logic                   r_phase;
    logic [F_W-1:0]         r_rem;
    logic [F_W-1:0]         r_den;
    logic [QUO_W-1:0]       r_q;
    logic [4:0]             r_cnt;
    logic [COORD_W-1:0]     r_xs0, r_ys0;
    logic [COORD_W-1:0]     r_xe, r_ye;
    t_seg                   r_pend;
    logic                   r_pend_v;
    t_seg                   r_out;
    logic                   r_out_v;

    logic signed [F_W-1:0]  f_pt [3];
    logic [COORD_W-1:0]     px [3];
    logic [COORD_W-1:0]     py [3];
    logic [2:0]             ch;
    logic                   seg_found;
    logic [1:0]             edge_a;
    logic [1:0]             start_edge;
    logic signed [F_W-1:0]  fa, fb;
    logic [F_W-1:0]         mag_a, mag_b;
    logic [COORD_W-1:0]     ca_x, cb_x, ca_y, cb_y;
    logic [F_W:0]           dbl;
    logic                   ge;
    logic [F_W-1:0]         rem_nx;
    logic [QUO_W-1:0]       q_nx;
    logic                   div_done;
    logic [COORD_W-1:0]     cx_now, cy_now;
    logic                   leg_last;
    logic                   lev_last;
    logic                   out_free;
    logic                   out_load;
    logic signed [F_W-1:0]  lv4;
    logic [SAMPLE_BITS-1:0] lvl;
    t_seg                   seg_new;

    function automatic logic strict_change(input logic signed [F_W-1:0] a,
                                           input logic signed [F_W-1:0] b);
        return ((a < 0) && (b > 0)) || ((a > 0) && (b < 0));
    endfunction

    function automatic logic [COORD_W-1:0] cross_coord(input logic [COORD_W-1:0] ca,
                                                       input logic [COORD_W-1:0] cb,
                                                       input logic [QUO_W-1:0] q);
        logic [QUO_W:0]     q16w;
        logic [QUO_W:0]     q15w;
        logic [COORD_W-1:0] mag;
        q16w = ({1'b0, q} + (QUO_W + 1)'(1)) >> 1;
        q15w = ({1'b0, q} + (QUO_W + 1)'(2)) >> 2;
        mag  = ((ca == HALF_Q16) || (cb == HALF_Q16)) ? COORD_W'(q15w) : COORD_W'(q16w);
        if (ca == cb) begin
            return ca;
        end
        return (cb > ca) ? ca + mag : ca - mag;
    endfunction

    // Points of the current triangle: two corners, then the centre.
    always_comb begin
        f_pt[0] = r_fv[CORNER0_Y[r_leg]][CORNER0_X[r_leg]];
        f_pt[1] = r_fv[CORNER1_Y[r_leg]][CORNER1_X[r_leg]];
        f_pt[2] = r_fc;
        px[0] = CORNER0_X[r_leg] ? ONE_Q16 : '0;
        py[0] = CORNER0_Y[r_leg] ? ONE_Q16 : '0;
        px[1] = CORNER1_X[r_leg] ? ONE_Q16 : '0;
        py[1] = CORNER1_Y[r_leg] ? ONE_Q16 : '0;
        px[2] = HALF_Q16;
        py[2] = HALF_Q16;
        ch[0] = strict_change(f_pt[0], f_pt[1]);
        ch[1] = strict_change(f_pt[1], f_pt[2]);
        ch[2] = strict_change(f_pt[2], f_pt[0]);
        seg_found = ($countones(ch) == 2);
        edge_a    = ch[0] ? 2'd0 : 2'd1;
    end

    assign start_edge = (r_state == ST_EVAL) ? edge_a : r_edge_b;

    always_comb begin
        case (start_edge)
            2'd1:    begin fa = f_pt[1]; fb = f_pt[2]; end
            2'd2:    begin fa = f_pt[2]; fb = f_pt[0]; end
            default: begin fa = f_pt[0]; fb = f_pt[1]; end
        endcase
        mag_a = (fa < 0) ? F_W'(-fa) : F_W'(fa);
        mag_b = (fb < 0) ? F_W'(-fb) : F_W'(fb);
    end

    always_comb begin
        case (r_edge)
            2'd1:    begin ca_x = px[1]; cb_x = px[2]; ca_y = py[1]; cb_y = py[2]; end
            2'd2:    begin ca_x = px[2]; cb_x = px[0]; ca_y = py[2]; cb_y = py[0]; end
            default: begin ca_x = px[0]; cb_x = px[1]; ca_y = py[0]; cb_y = py[1]; end
        endcase
    end

    // One restoring division step per cycle.
    always_comb begin
        dbl      = {r_rem, 1'b0};
        ge       = (dbl >= {1'b0, r_den});
        rem_nx   = ge ? F_W'(dbl - {1'b0, r_den}) : F_W'(dbl);
        q_nx     = {r_q[QUO_W-2:0], ge};
        div_done = (r_cnt == 5'(QUO_W - 1));
        cx_now   = cross_coord(ca_x, cb_x, q_nx);
        cy_now   = cross_coord(ca_y, cb_y, q_nx);
    end

    assign leg_last = (r_leg == 2'd3);
    assign lev_last = ({1'b0, r_li} == i_cfg.nlev - NLEV_W'(1));
    assign out_free = !r_out_v || o_seg.ready;
    assign lvl      = i_cfg.levels[r_li];
    assign lv4      = sext(lvl) <<< 2;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_q_valid) n_state = ST_LEVEL;
            ST_LEVEL: n_state = ST_EVAL;
            ST_EVAL: begin
                if (seg_found) begin
                    n_state = ST_DIV;
                end else if (leg_last) begin
                    n_state = lev_last ? ST_FLUSH : ST_LEVEL;
                end
            end
            ST_DIV:   if (div_done && r_phase) n_state = ST_EMIT;
            ST_EMIT: begin
                if (!r_pend_v || out_free) begin
                    if (leg_last) begin
                        n_state = lev_last ? ST_FLUSH : ST_LEVEL;
                    end else begin
                        n_state = ST_EVAL;
                    end
                end
            end
            ST_FLUSH: if (!r_pend_v || out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        unique case (r_state)
            ST_IDLE:  ctl.pop = i_q_valid;
            ST_LEVEL: ctl.load_f = 1'b1;
            ST_EVAL: begin
                ctl.start = seg_found;
                ctl.adv   = !seg_found;
            end
            ST_DIV: begin
                ctl.step  = 1'b1;
                ctl.start = div_done && !r_phase;
            end
            ST_EMIT: begin
                ctl.emit = !r_pend_v || out_free;
                ctl.adv  = !r_pend_v || out_free;
            end
            ST_FLUSH: ctl.flush_out = r_pend_v && out_free;
            default:  ctl = '0;
        endcase
    end

    assign o_q_pop  = ctl.pop;
    assign out_load = (ctl.emit && r_pend_v) || ctl.flush_out;

    always_comb begin
        seg_new.cell_column = r_cell.col;
        seg_new.cell_row    = r_cell.row;
        seg_new.level_index = r_li;
        seg_new.triangle    = r_leg;
        seg_new.start_x     = r_xs0;
        seg_new.start_y     = r_ys0;
        seg_new.end_x       = r_xe;
        seg_new.end_y       = r_ye;
        seg_new.last        = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctl.emit) begin
                r_pend_v <= 1'b1;
            end else if (ctl.flush_out) begin
                r_pend_v <= 1'b0;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (o_seg.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.pop) begin
            r_cell <= i_q_cell;
            r_li   <= '0;
        end
        if (ctl.load_f) begin
            r_fv[0][0] <= (sext(r_cell.v00) <<< 2) - lv4;
            r_fv[0][1] <= (sext(r_cell.v01) <<< 2) - lv4;
            r_fv[1][0] <= (sext(r_cell.v10) <<< 2) - lv4;
            r_fv[1][1] <= (sext(r_cell.v11) <<< 2) - lv4;
            r_fc       <= sext(r_cell.v00) + sext(r_cell.v01)
                        + sext(r_cell.v10) + sext(r_cell.v11) - lv4;
            r_leg      <= '0;
        end
        if (ctl.adv) begin
            if (leg_last) begin
                r_li <= r_li + LEV_W'(1);
            end else begin
                r_leg <= r_leg + 2'd1;
            end
        end
        if (ctl.step) begin
            if (!ctl.start) begin
                r_rem <= rem_nx;
                r_q   <= q_nx;
                r_cnt <= r_cnt + 5'd1;
            end
            if (div_done && !r_phase) begin
                r_xs0 <= cx_now;
                r_ys0 <= cy_now;
            end
            if (div_done && r_phase) begin
                r_xe <= cx_now;
                r_ye <= cy_now;
            end
        end
        if (ctl.start) begin
            r_rem   <= mag_a;
            r_den   <= mag_a + mag_b;
            r_q     <= '0;
            r_cnt   <= '0;
            r_edge  <= start_edge;
            r_phase <= (r_state == ST_DIV);
            if (r_state == ST_EVAL) begin
                r_edge_b <= ch[2] ? 2'd2 : 2'd1;
            end
        end
        if (ctl.emit) begin
            r_pend <= seg_new;
        end
        // The held segment never carries last until the cell is finished.
        if (ctl.emit && r_pend_v) begin
            r_out <= r_pend;
        end
        if (ctl.flush_out) begin
            r_out <= {r_pend[$bits(t_seg)-1:1], 1'b1};
        end
    end

    assign o_seg.valid       = r_out_v;
    assign o_seg.cell_column = r_out.cell_column;
    assign o_seg.cell_row    = r_out.cell_row;
    assign o_seg.level_index = r_out.level_index;
    assign o_seg.triangle    = r_out.triangle;
    assign o_seg.start_x     = r_out.start_x;
    assign o_seg.start_y     = r_out.start_y;
    assign o_seg.end_x       = r_out.end_x;
    assign o_seg.end_y       = r_out.end_y;
    assign o_seg.last        = r_out.last;

    `CSE_ASSERT_NOW(a_out_load_free, i_clk, i_rst_n, out_load, out_free)
    `CSE_ASSERT_NOW(a_level_in_use, i_clk, i_rst_n,
        (r_state != ST_IDLE) && (r_state != ST_FLUSH), ({1'b0, r_li} < i_cfg.nlev))
    `CSE_ASSERT_NOW(a_rem_below_den, i_clk, i_rst_n, r_state == ST_DIV, r_rem < r_den)
    `CSE_ASSERT_NEXT(a_flush_clears, i_clk, i_rst_n, ctl.flush_out, !r_pend_v && r_out_v)
endmodule
